FILE: hdl/tlin_pkg.sv
package tlin_pkg;

  // Table geometry and arithmetic widths.
  localparam int ROW_COUNT_MAX = 256;
  localparam int ROW_BITS      = $clog2(ROW_COUNT_MAX);
  localparam int CFG_BITS      = 9;
  localparam int VALUE_BITS    = 32;
  localparam int WORD_BITS     = 32;
  localparam int COEF_BITS     = 3 * WORD_BITS;
  localparam int PROD_BITS     = 2 * WORD_BITS;
  localparam int DIV_CNT_BITS  = $clog2(PROD_BITS + 1);
  localparam int M_CAP_BITS    = 50;
  localparam int RES_BITS      = M_CAP_BITS + 3;

  localparam logic [PROD_BITS-1:0] M_CAP     = PROD_BITS'(1) << M_CAP_BITS;
  localparam logic [RES_BITS-1:0]  VALUE_MAX = (RES_BITS'(1) << VALUE_BITS) - RES_BITS'(1);
  localparam logic [CFG_BITS-1:0]  ROWS_CAP  = CFG_BITS'(ROW_COUNT_MAX);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INSIDE       = 2'd0,
    ST_EXTRAPOLATED = 2'd1,
    ST_CLAMPED      = 2'd2,
    ST_INVALID      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    COL_FIRST  = 2'd0,
    COL_SECOND = 2'd1,
    COL_THIRD  = 2'd2
  } column_t;

  typedef struct packed {
    opcode_t        opcode;
    logic [7:0]     row_index;
    logic [31:0]    energy;
    logic [31:0]    coef_first;
    logic [31:0]    coef_second;
    logic [31:0]    coef_third;
    logic [1:0]     column_select;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } out_item_t;

  // Write port of the row store.
  typedef struct packed {
    logic                 en;
    logic [ROW_BITS-1:0]  addr;
    logic [WORD_BITS-1:0] energy;
    logic [COEF_BITS-1:0] coef;
  } tbl_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH_LO,
    S_LOAD_LO,
    S_PREP,
    S_MULT,
    S_DIV_START,
    S_DIV_WAIT,
    S_FINISH,
    S_DONE
  } state_t;

  // Picks one coefficient column out of a stored row; code three reads the third column.
  function automatic logic [WORD_BITS-1:0] pick_column(input logic [COEF_BITS-1:0] row,
                                                       input logic [1:0] sel);
    logic [WORD_BITS-1:0] r;
    case (sel)
      COL_FIRST:  r = row[WORD_BITS-1:0];
      COL_SECOND: r = row[2*WORD_BITS-1:WORD_BITS];
      default:    r = row[3*WORD_BITS-1:2*WORD_BITS];
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/tlin_table.sv
module tlin_table
  import tlin_pkg::*;
(
  input  logic                 clk,
  input  tbl_wr_t              wr,
  input  logic [ROW_BITS-1:0]  rd_addr,
  output logic [WORD_BITS-1:0] rd_energy,
  output logic [COEF_BITS-1:0] rd_coef
);

  logic [WORD_BITS-1:0] energy_mem [ROW_COUNT_MAX];
  logic [COEF_BITS-1:0] coef_mem   [ROW_COUNT_MAX];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      energy_mem[wr.addr] <= wr.energy;
      coef_mem[wr.addr]   <= wr.coef;
    end
  end

  // Registered read, one row per cycle.
  always_ff @(posedge clk) begin
    rd_energy <= energy_mem[rd_addr];
    rd_coef   <= coef_mem[rd_addr];
  end

endmodule

FILE: hdl/tlin_divider.sv
module tlin_divider
  import tlin_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [PROD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 done,
  output logic [PROD_BITS-1:0] quotient
);

  // Restoring division, one quotient bit per cycle.
  logic [WORD_BITS-1:0]    rem;
  logic [PROD_BITS-1:0]    quot;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic [WORD_BITS:0]      rem_sh;
  logic                    q_bit;
  logic [WORD_BITS-1:0]    rem_next;

  always_comb begin
    rem_sh   = {rem, quot[PROD_BITS-1]};
    q_bit    = rem_sh >= {1'b0, divisor};
    rem_next = q_bit ? WORD_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(PROD_BITS);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_BITS'(1);
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[PROD_BITS-2:0], q_bit};
      rem  <= rem_next;
    end
  end

  assign quotient = quot;

endmodule

FILE: hdl/table_linear_interpolator.sv
// Piecewise-linear table interpolator.
// Input channel (in_valid/in_ready/in_item): a write item stores one row (energy and three
// coefficient columns, Q16.16) and produces no result; a query item produces exactly one
// result item on the output channel (out_valid/out_ready/out_item) with the interpolated
// value and a status code.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) sets the number of rows searched;
// it is always ready and should only be written while the block is idle.
// A write item is stored and leaves the block idle. For a query, the search reads one
// row per cycle through the single read port of the row store and stops at a row from
// 1 to 255; the lower row fetch, set-up and multiply follow, then the bit-serial divider
// and the final step and hand-over. A zero-width segment skips the arithmetic, and a
// query with fewer than two rows in use skips the search as well. in_ready stays low
// from the query until out_valid rises, and rises with it. Results sit in an output
// register, so further items are taken while a result waits; if a second query
// finishes before the first result has been taken, it holds in its hand-over until
// the output register frees up.
// Reset is synchronous: the row count returns to zero and the output empties. The row
// store is not cleared; rows must be written before a query reads them.
module table_linear_interpolator
  import tlin_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_data
);

  state_t state, state_next;

  // Configuration.
  logic [CFG_BITS-1:0] rows_in_use;

  // Query context.
  logic [WORD_BITS-1:0] q_energy;
  logic [1:0]           q_col;
  logic [ROW_BITS-1:0]  last_row;
  logic [ROW_BITS-1:0]  idx;
  logic [ROW_BITS-1:0]  cmp_idx;
  logic                 cmp_valid;
  logic [ROW_BITS-1:0]  hi_row;

  // Segment end points.
  logic [WORD_BITS-1:0] e_hi, e_lo, c_hi, c_lo;

  // Magnitudes of the three differences and their combined sign.
  logic [WORD_BITS-1:0] span_mag, dc_mag, de_mag;
  logic                 neg;
  logic                 in_segment;
  logic [PROD_BITS-1:0] prod;

  // Result waiting to go to the output register.
  out_item_t pend;

  // Row store and divider connections.
  tbl_wr_t              tbl_wr;
  logic [ROW_BITS-1:0]  rd_addr;
  logic [WORD_BITS-1:0] rd_energy;
  logic [COEF_BITS-1:0] rd_coef;
  logic                 div_start, div_done;
  logic [PROD_BITS-1:0] div_quot;

  // Combinational helpers.
  logic                 in_acc, query_acc, out_free;
  logic [CFG_BITS-1:0]  rows_eff;
  logic                 search_hit;
  logic [WORD_BITS-1:0] rd_col;
  logic                 span_neg, dc_neg, de_neg;
  logic [WORD_BITS-1:0] span_abs, dc_abs, de_abs;
  logic [RES_BITS-1:0]  m_capped, c_ext, res_sum;
  out_item_t            fin;

  tlin_table u_table (
    .clk       (clk),
    .wr        (tbl_wr),
    .rd_addr   (rd_addr),
    .rd_energy (rd_energy),
    .rd_coef   (rd_coef)
  );

  tlin_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (span_mag),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign query_acc = in_acc && (in_item.opcode == OP_QUERY);
  assign out_free  = !out_valid || out_ready;
  assign rows_eff  = (rows_in_use > ROWS_CAP) ? ROWS_CAP : rows_in_use;
  assign rd_col    = pick_column(rd_coef, q_col);

  // The search stops at the first row above the query energy, or at the last row in use.
  assign search_hit = cmp_valid && ((rd_energy > q_energy) || (cmp_idx == last_row));

  // Differences of the segment, taken as magnitude and sign.
  always_comb begin
    span_neg = e_hi < e_lo;
    dc_neg   = c_hi < c_lo;
    de_neg   = e_hi < q_energy;
    span_abs = span_neg ? (e_lo - e_hi) : (e_hi - e_lo);
    dc_abs   = dc_neg ? (c_lo - c_hi) : (c_hi - c_lo);
    de_abs   = de_neg ? (q_energy - e_hi) : (e_hi - q_energy);
  end

  // Final correction of the upper coefficient, then saturation.
  always_comb begin
    m_capped = (div_quot > M_CAP) ? RES_BITS'(M_CAP) : RES_BITS'(div_quot);
    c_ext    = RES_BITS'(c_hi);
    res_sum  = neg ? (c_ext + m_capped) : (c_ext - m_capped);
    if (res_sum[RES_BITS-1]) begin
      fin.value  = '0;
      fin.status = ST_CLAMPED;
    end else if (res_sum > VALUE_MAX) begin
      fin.value  = VALUE_MAX[31:0];
      fin.status = ST_CLAMPED;
    end else begin
      fin.value  = res_sum[31:0];
      fin.status = in_segment ? ST_INSIDE : ST_EXTRAPOLATED;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (query_acc) begin
          state_next = (rows_eff < CFG_BITS'(2)) ? S_DONE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (search_hit) begin
          state_next = S_FETCH_LO;
        end
      end
      S_FETCH_LO:  state_next = S_LOAD_LO;
      S_LOAD_LO:   state_next = S_PREP;
      S_PREP:      state_next = (e_hi == e_lo) ? S_DONE : S_MULT;
      S_MULT:      state_next = S_DIV_START;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH:    state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready      = 1'b0;
    div_start     = 1'b0;
    rd_addr       = idx;
    tbl_wr.en     = 1'b0;
    tbl_wr.addr   = ROW_BITS'(in_item.row_index);
    tbl_wr.energy = in_item.energy;
    tbl_wr.coef   = {in_item.coef_third, in_item.coef_second, in_item.coef_first};
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        tbl_wr.en = in_valid && (in_item.opcode == OP_WRITE)
                    && (int'(in_item.row_index) < ROW_COUNT_MAX);
      end
      S_FETCH_LO:  rd_addr   = hi_row - ROW_BITS'(1);
      S_DIV_START: div_start = 1'b1;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rows_in_use <= '0;
      out_valid   <= 1'b0;
      cmp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        rows_in_use <= cfg_data;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      cmp_valid <= (state == S_SEARCH) && !search_hit;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        q_energy   <= in_item.energy;
        q_col      <= in_item.column_select;
        last_row   <= ROW_BITS'(rows_eff - CFG_BITS'(1));
        idx        <= ROW_BITS'(1);
        pend.value <= '0;
        pend.status <= ST_INVALID;
      end
      S_SEARCH: begin
        // One row address goes out each cycle; its energy is compared in the next cycle.
        cmp_idx <= idx;
        if (idx != last_row) begin
          idx <= idx + ROW_BITS'(1);
        end
        if (search_hit) begin
          hi_row <= cmp_idx;
          e_hi   <= rd_energy;
          c_hi   <= rd_col;
        end
      end
      S_LOAD_LO: begin
        e_lo <= rd_energy;
        c_lo <= rd_col;
      end
      S_PREP: begin
        span_mag    <= span_abs;
        dc_mag      <= dc_abs;
        de_mag      <= de_abs;
        neg         <= dc_neg ^ de_neg ^ span_neg;
        in_segment  <= (q_energy >= (span_neg ? e_hi : e_lo))
                       && (q_energy <= (span_neg ? e_lo : e_hi));
        pend.value  <= c_hi;
        pend.status <= ST_INVALID;
      end
      S_MULT:   prod <= PROD_BITS'(dc_mag) * PROD_BITS'(de_mag);
      S_FINISH: pend <= fin;
      default: ;
    endcase
    if (state == S_DONE && out_free) begin
      out_item <= pend;
    end
  end

endmodule

FILE: hdl/tlin_checker.sv
module tlin_checker
  import tlin_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // A result that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // Once a query is taken the block works on it and takes nothing else next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.opcode == OP_QUERY |=> !in_ready)
    else $error("input taken straight after a query");

  // A clamped result sits at one of the two limits of the output range.
  a_clamp_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_CLAMPED |->
      out_item.value == 32'd0 || out_item.value == 32'hFFFF_FFFF)
    else $error("clamped result not at a limit");

  // After reset the output is empty and the input side is open.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind table_linear_interpolator tlin_checker u_tlin_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
